### sv/bfws_pkg.sv
// Package for the band-filling wavetable oscillator.
// Holds the beat types, opcodes and fixed-point constants shared by the design.
// Depends on nothing.
package bfws_pkg;

    // Table length in words and the most partials summed for one sample.
    // The table length must be a power of two so that wrapping is a mask.
    localparam int TABLE_SIZE  = 1024;
    localparam int PARTIAL_CAP = 64;

    // Fractional bits of the fixed-point formats.
    localparam int INC_FRAC = 20;   // increments, Q12.20
    localparam int AMP_FRAC = 16;   // amplitudes, Q8.16
    localparam int OUT_FRAC = 15;   // table words, Q1.15

    // Derived widths.
    localparam int ADDR_W = $clog2(TABLE_SIZE);
    localparam int POS_W  = ADDR_W + INC_FRAC;
    localparam int CNT_W  = $clog2(PARTIAL_CAP + 1);

    // Opcodes of an input beat.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // One input beat.
    typedef struct packed {
        logic               opcode;
        logic        [9:0]  table_index;
        logic signed [15:0] table_word;
        logic signed [23:0] amp;
        logic signed [23:0] amp_factor;
        logic signed [31:0] inc_start;
        logic signed [31:0] inc_limit;
        logic signed [31:0] inc_step;
    } t_in_beat;

    // One output beat.
    typedef struct packed {
        logic signed [31:0] sample;
        logic               partial_cap_hit;
    } t_out_beat;

endpackage

### sv/bfws_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Width and depth are parameters; no other dependencies.
module bfws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read share the one address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/band_fill_wavetable_synth.sv
// Band-filling additive wavetable oscillator, top level.
// Depends on bfws_pkg and bfws_ram.
// A table-write beat leaves the block idle, so another beat can follow in the next cycle.
// A sample beat runs up to PARTIAL_CAP partials, each passing in turn through the
// position multiply, table read, multiply and accumulate, and then waits in a
// finishing state for a free output slot. Output sits in a register, so the next
// beat is taken while a result waits. Synchronous reset clears the control state and
// the time counter; the wavetable holds no defined contents until written.
module band_fill_wavetable_synth (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bfws_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bfws_pkg::t_out_beat o_out_beat
);
    import bfws_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POS,
        S_READ,
        S_MAC,
        S_UPD,
        S_FIN
    } t_state;

    t_state                    r_state;
    logic        [31:0]        r_time;
    logic signed [31:0]        r_inc;
    logic signed [31:0]        r_lim;
    logic signed [31:0]        r_step;
    logic signed [23:0]        r_namp;
    logic signed [23:0]        r_afac;
    logic        [CNT_W-1:0]   r_count;
    logic        [POS_W-1:0]   r_pos;
    logic                      r_nonzero;
    logic signed [39:0]        r_term;
    logic signed [63:0]        r_incprod;
    logic signed [47:0]        r_ampprod;
    logic                      r_more;
    logic signed [47:0]        r_acc;
    logic                      r_cap;
    logic                      r_out_valid;
    t_out_beat                 r_out;

    logic                      in_fire;
    logic                      wr_en;
    logic                      slot_free;
    logic        [ADDR_W-1:0]  ram_addr;
    logic        [15:0]        ram_rdata;
    logic        [POS_W-1:0]   inc_ext;
    logic        [POS_W-1:0]   time_ext;
    logic        [POS_W-1:0]   pos_prod;
    logic signed [39:0]        term_prod;
    logic        [31:0]        step_mag;
    logic signed [63:0]        inc_prod;
    logic signed [47:0]        amp_prod;
    logic signed [32:0]        inc_sum;
    logic signed [31:0]        inc_add_sat;
    logic signed [63:0]        inc_shift;
    logic signed [31:0]        inc_mul_sat;
    logic signed [31:0]        inc_next;
    logic signed [47:0]        amp_shift;
    logic signed [23:0]        amp_next;
    logic signed [47:0]        acc_shift;
    logic signed [31:0]        sample_sat;

    // Handshake: one beat at a time, output parted by its own register.
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // Table write happens only in idle; reads happen only during a sample.
    assign wr_en = in_fire && (i_in_beat.opcode == OP_WRITE) &&
                   (32'(i_in_beat.table_index) < 32'(TABLE_SIZE));
    assign ram_addr = (r_state == S_IDLE) ? ADDR_W'(i_in_beat.table_index)
                                          : r_pos[POS_W-1:INC_FRAC];

    bfws_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_SIZE)
    ) u_wave_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_re    (r_state == S_READ),
        .i_addr  (ram_addr),
        .i_wdata (i_in_beat.table_word),
        .o_rdata (ram_rdata)
    );

    // Wrapped position: only the low table-plus-fraction bits of inc * time matter.
    assign inc_ext  = POS_W'(r_inc);
    assign time_ext = POS_W'(r_time);
    assign pos_prod = POS_W'(inc_ext * time_ext);

    // Products for the weighted term and the next partial's increment and amplitude.
    assign term_prod = r_namp * $signed(ram_rdata);
    assign step_mag  = ~r_step + 32'd1;
    assign inc_prod  = r_inc * $signed({1'b0, step_mag});
    assign amp_prod  = r_namp * r_afac;

    // Additive increment step, saturated.
    assign inc_sum = 33'(r_inc) + 33'(r_step);
    always_comb begin
        if (inc_sum[32] != inc_sum[31]) begin
            inc_add_sat = inc_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            inc_add_sat = inc_sum[31:0];
        end
    end

    // Multiplicative increment step, floored and saturated.
    assign inc_shift = r_incprod >>> INC_FRAC;
    always_comb begin
        if ((&inc_shift[63:31]) || !(|inc_shift[63:31])) begin
            inc_mul_sat = inc_shift[31:0];
        end else begin
            inc_mul_sat = inc_shift[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    // Choose the step rule by the sign of the step.
    always_comb begin
        if (r_step[31]) begin
            inc_next = inc_mul_sat;
        end else if (r_step != 32'sd0) begin
            inc_next = inc_add_sat;
        end else begin
            inc_next = r_inc;
        end
    end

    // Next amplitude, floored and saturated to 24 bits.
    assign amp_shift = r_ampprod >>> AMP_FRAC;
    always_comb begin
        if ((&amp_shift[47:23]) || !(|amp_shift[47:23])) begin
            amp_next = amp_shift[23:0];
        end else begin
            amp_next = amp_shift[47] ? 24'sh80_0000 : 24'sh7F_FFFF;
        end
    end

    // Final sample, floored to Q16.16 and saturated.
    assign acc_shift = r_acc >>> OUT_FRAC;
    always_comb begin
        if ((&acc_shift[47:31]) || !(|acc_shift[47:31])) begin
            sample_sat = acc_shift[31:0];
        end else begin
            sample_sat = acc_shift[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    // Sequencer: position, table read, multiply, accumulate and step, per partial.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_time      <= '0;
            r_out_valid <= 1'b0;
            r_cap       <= 1'b0;
            r_count     <= '0;
            r_nonzero   <= 1'b0;
            r_more      <= 1'b0;
        end else begin
            // In the finishing state the output slot is reloaded instead.
            if (r_out_valid && i_out_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire && (i_in_beat.opcode == OP_SAMPLE)) begin
                        r_inc     <= i_in_beat.inc_start;
                        r_lim     <= i_in_beat.inc_limit;
                        r_step    <= i_in_beat.inc_step;
                        r_namp    <= i_in_beat.amp;
                        r_afac    <= i_in_beat.amp_factor;
                        r_count   <= CNT_W'(1);
                        r_acc     <= '0;
                        r_cap     <= 1'b0;
                        r_nonzero <= 1'b0;
                        r_state   <= S_POS;
                    end
                end
                S_POS: begin
                    r_pos   <= pos_prod;
                    r_state <= S_READ;
                end
                S_READ: begin
                    if (r_pos != '0) begin
                        r_nonzero <= 1'b1;
                    end
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    r_term    <= term_prod;
                    r_incprod <= inc_prod;
                    r_ampprod <= amp_prod;
                    r_more    <= (r_inc < r_lim);
                    r_state   <= S_UPD;
                end
                S_UPD: begin
                    r_acc <= r_acc + 48'(r_term);
                    if (!r_more) begin
                        r_state <= S_FIN;
                    end else if (r_count >= CNT_W'(PARTIAL_CAP)) begin
                        r_cap   <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_inc   <= inc_next;
                        r_namp  <= amp_next;
                        r_count <= r_count + CNT_W'(1);
                        r_state <= S_POS;
                    end
                end
                S_FIN: begin
                    if (slot_free) begin
                        r_out.sample          <= sample_sat;
                        r_out.partial_cap_hit <= r_cap;
                        r_out_valid           <= 1'b1;
                        r_time  <= r_nonzero ? (r_time + 32'd1) : 32'd1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The partial count never runs past the cap.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(PARTIAL_CAP))
        else $error("partial count beyond cap");

    // A cap flag is only raised with the count at the cap.
    a_cap_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_cap) |-> (r_count == CNT_W'(PARTIAL_CAP)))
        else $error("cap flag without full partial count");

    // A result appears only out of the finishing state.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result loaded outside finishing state");

    // A finished sample with a free slot is delivered and the block goes idle.
    a_fin_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && slot_free) |=> (r_state == S_IDLE && r_out_valid))
        else $error("finished sample not handed off");

    // The table is never written while a sample is being computed.
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_IDLE && !(r_state == S_READ)))
        else $error("table write during a sample");

endmodule

### sim/tb_band_fill_wavetable_synth.sv
// Self-checking testbench for the band-filling wavetable oscillator.
// Depends on bfws_pkg and the band_fill_wavetable_synth RTL.
// It preloads the table, walks a directed table, then runs random beats against a predictor.
`timescale 1ns / 100ps

module tb_band_fill_wavetable_synth;

    import bfws_pkg::*;

    localparam int     STALL_LIMIT  = 20000;
    localparam int     RANDOM_BEATS = 550;
    localparam int     HOLD_CYCLES  = 1500;
    localparam int     HOLD_AFTER   = 60;
    localparam int     DRAIN_CYCLES = 300;
    localparam longint I32_MIN      = -(longint'(1) <<< 31);
    localparam longint I32_MAX      = (longint'(1) <<< 31) - 1;
    localparam longint A24_MIN      = -(longint'(1) <<< 23);
    localparam longint A24_MAX      = (longint'(1) <<< 23) - 1;
    localparam longint POS_MOD      = longint'(TABLE_SIZE) <<< INC_FRAC;

    // One row of the directed table; typed rows carry their own expected result.
    typedef struct packed {
        t_in_beat  beat;
        logic      typed;
        t_out_beat want;
    } t_dir_row;

    logic      i_clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      out_ready = 1'b0;
    t_in_beat  in_beat = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_beat o_out_beat;

    // Predictor state: the wavetable copy and the sample time counter.
    logic signed [15:0] wave_mem [TABLE_SIZE];
    int unsigned        phase_count = 0;

    t_out_beat expected_samples[$];
    t_dir_row  dir_rows[$];
    int        fail_count   = 0;
    int        results_seen = 0;
    int        stall_cycles = 0;
    int        burst_left   = 0;

    band_fill_wavetable_synth u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (o_out_beat)
    );

    // Free-running clock.
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Wrapped table index of one partial at the current sample time.
    function automatic int wrap_index(longint inc, longint t, ref bit any_nonzero);
        longint pos;
        pos = (inc * t) % POS_MOD;
        if (pos < 0) pos += POS_MOD;
        if (pos != 0) any_nonzero = 1'b1;
        return int'(pos >>> INC_FRAC);
    endfunction

    // Applies one accepted beat to the predictor state; returns 1 with the expected
    // sample when the beat produces one.
    function automatic bit synth_predict(input t_in_beat b, output t_out_beat r);
        longint inc, lim, stp, gain, factor, acc, t;
        int     nparts;
        int     idx;
        bit     any_nonzero;
        bit     capped;
        r = '0;
        if (b.opcode == OP_WRITE) begin
            wave_mem[b.table_index] = b.table_word;
            return 1'b0;
        end
        gain        = longint'($signed(b.amp));
        factor      = longint'($signed(b.amp_factor));
        inc         = longint'($signed(b.inc_start));
        lim         = longint'($signed(b.inc_limit));
        stp         = longint'($signed(b.inc_step));
        t           = longint'(phase_count);
        any_nonzero = 1'b0;
        capped      = 1'b0;
        idx         = wrap_index(inc, t, any_nonzero);
        acc         = gain * longint'(wave_mem[idx]);
        nparts      = 1;
        while (inc < lim && !capped) begin
            if (nparts >= PARTIAL_CAP) begin
                capped = 1'b1;
            end else begin
                if (stp > 0) begin
                    inc = clamp(inc + stp, I32_MIN, I32_MAX);
                end else if (stp < 0) begin
                    inc = clamp((inc * -stp) >>> INC_FRAC, I32_MIN, I32_MAX);
                end
                idx    = wrap_index(inc, t, any_nonzero);
                gain   = clamp((gain * factor) >>> AMP_FRAC, A24_MIN, A24_MAX);
                acc   += gain * longint'(wave_mem[idx]);
                nparts = nparts + 1;
            end
        end
        phase_count       = any_nonzero ? phase_count + 1 : 1;
        r.sample          = 32'(clamp(acc >>> OUT_FRAC, I32_MIN, I32_MAX));
        r.partial_cap_hit = capped;
        return 1'b1;
    endfunction

    function automatic t_in_beat mk_write(int idx, int word);
        t_in_beat b;
        b.opcode      = OP_WRITE;
        b.table_index = 10'(idx);
        b.table_word  = 16'(word);
        b.amp         = 24'($urandom);
        b.amp_factor  = 24'($urandom);
        b.inc_start   = $urandom;
        b.inc_limit   = $urandom;
        b.inc_step    = $urandom;
        return b;
    endfunction

    function automatic t_in_beat mk_sample(longint amp, longint factor, longint start,
                                           longint limit, longint step);
        t_in_beat b;
        b.opcode      = OP_SAMPLE;
        b.table_index = 10'($urandom);
        b.table_word  = 16'($urandom);
        b.amp         = 24'(amp);
        b.amp_factor  = 24'(factor);
        b.inc_start   = 32'(start);
        b.inc_limit   = 32'(limit);
        b.inc_step    = 32'(step);
        return b;
    endfunction

    // Random sample beat: mostly increment ramps that run a useful number of
    // partials, some fully random fields.
    function automatic t_in_beat rand_sample_beat();
        t_in_beat    b;
        longint      start, stp, lim;
        int unsigned kind;
        b    = mk_sample(longint'($urandom), longint'($urandom), longint'($urandom),
                         longint'($urandom), longint'($urandom));
        kind = $urandom_range(0, 9);
        if (kind >= 2) begin
            b.amp_factor = 24'($urandom_range(16384, 65536));
            if ($urandom_range(0, 1) == 1) b.amp_factor = -b.amp_factor;
            start = longint'($urandom_range(0, 1 << 27)) - (longint'(1) <<< 26);
            case (kind)
                2, 3, 4, 5: begin
                    // Additive ramp, sometimes long enough to reach the cap.
                    stp = longint'($urandom_range(1, 1 << 24));
                    lim = start + stp * longint'($urandom_range(0, 70));
                end
                6, 7, 8: begin
                    // Multiplicative ramp by a factor between one and three.
                    start = longint'($urandom_range(1, 1 << 22));
                    stp   = -longint'($urandom_range(1 << 20, 3 << 20));
                    lim   = longint'($urandom_range(1, 1 << 30));
                end
                default: begin
                    // Frozen increment: one partial or a run to the cap.
                    if ($urandom_range(0, 1) == 1) start = 0;
                    stp = 0;
                    lim = start + longint'($urandom_range(0, 1));
                end
            endcase
            b.inc_start = 32'(start);
            b.inc_step  = 32'(stp);
            b.inc_limit = 32'(lim);
        end
        return b;
    endfunction

    task automatic add_row(input t_in_beat b, input bit typed, input longint smp,
                           input bit cap);
        t_dir_row row;
        row.beat                 = b;
        row.typed                = typed;
        row.want.sample          = 32'(smp);
        row.want.partial_cap_hit = cap;
        dir_rows.push_back(row);
    endtask

    // Offers one beat in the current burst, inserting a random gap between bursts,
    // then records the expected sample once the beat is accepted.
    task automatic send_beat(input t_in_beat b, input bit typed, input t_out_beat want);
        t_out_beat predicted;
        int        gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                @(negedge i_clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left = burst_left - 1;
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        if (synth_predict(b, predicted)) begin
            expected_samples.push_back(typed ? want : predicted);
        end
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        in_valid  <= 1'b0;
        burst_left = 0;
    endtask

    // Main sequence: reset, table preload, directed table, random beats, drain.
    initial begin : stimulus
        int       i;
        t_in_beat b;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // Every table word is written before any sample can read it.
        for (i = 0; i < TABLE_SIZE; i++) begin
            send_beat(mk_write(i, int'($urandom)), 1'b0, '0);
        end

        // First sample after reset sits at time zero and is silent.
        add_row(mk_sample(0, 0, 0, 0, 0), 1'b1, 0, 1'b0);
        add_row(mk_write(0, -32768), 1'b0, 0, 1'b0);
        add_row(mk_write(1023, 32767), 1'b0, 0, 1'b0);
        // Frozen zero increment: all partials hit entry zero until the cap.
        add_row(mk_sample(-8388608, 65536, 0, 1, 0), 1'b1, 536870912, 1'b1);
        add_row(mk_write(0, 32767), 1'b0, 0, 1'b0);
        // Single partial with the largest amplitudes of either sign.
        add_row(mk_sample(8388607, 0, 0, 0, 0), 1'b1, 8388351, 1'b0);
        add_row(mk_sample(-8388608, 0, 0, I32_MIN, 0), 1'b1, -8388352, 1'b0);
        // Added step, doubling, and a negative increment that runs to the cap.
        add_row(mk_sample(1 << 16, 1 << 15, 1 << 20, 9 << 20, 1 << 20), 1'b0, 0, 1'b0);
        add_row(mk_sample(-(3 << 16), 3 << 14, 1 << 20, 40 << 20, -(2 << 20)),
                1'b0, 0, 1'b0);
        add_row(mk_sample(5 << 16, -(1 << 15), -(3 << 20), 5 << 20, -(3 << 20)),
                1'b0, 0, 1'b0);
        // Increment extremes and saturating steps.
        add_row(mk_sample(8388607, 8388607, I32_MAX, I32_MIN, I32_MAX), 1'b0, 0, 1'b0);
        add_row(mk_sample(-8388608, -8388608, I32_MIN, I32_MAX, I32_MAX), 1'b0, 0, 1'b0);
        add_row(mk_sample(8388607, -65536, 1, I32_MAX, I32_MIN), 1'b0, 0, 1'b0);
        // Fractional increments, a tiny step to the cap, and a shrinking increment.
        add_row(mk_sample(1 << 20, 1 << 16, 1 << 19, 100 << 20, 1 << 18), 1'b0, 0, 1'b0);
        add_row(mk_sample(123456, 40000, 0, I32_MAX, 1), 1'b0, 0, 1'b0);
        add_row(mk_sample(-777777, 50000, 7 << 20, 8 << 20, -(1 << 19)), 1'b0, 0, 1'b0);
        add_row(mk_write(512, 0), 1'b0, 0, 1'b0);
        // Amplitude growth that saturates.
        add_row(mk_sample(8388607, 8388607, 3 << 20, 200 << 20, 5 << 20), 1'b0, 0, 1'b0);
        for (i = 0; i < dir_rows.size(); i++) begin
            send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random mix of table writes and sample beats.
        for (i = 0; i < RANDOM_BEATS; i++) begin
            if (i == RANDOM_BEATS / 2) begin
                // Let the block drain completely before going on.
                drop_valid();
                while (expected_samples.size() != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 9) < 3) begin
                b = mk_write(int'($urandom), int'($urandom));
            end else begin
                b = rand_sample_beat();
            end
            send_beat(b, 1'b0, '0);
        end

        drop_valid();
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("band_fill_wavetable_synth verification clean");
        end else begin
            $display("band_fill_wavetable_synth verification failed");
        end
        $finish;
    end

    // Receiver: spans of steady, random and sparse ready, plus one long hold-off
    // so that the block backs up into its input.
    initial begin : receiver
        int  mode;
        int  span;
        int  k;
        bit  hold_done;
        hold_done = 1'b0;
        forever begin
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                @(negedge i_clk);
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 120);
            for (k = 0; k < span; k++) begin
                @(negedge i_clk);
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 1) == 1);
                    2:       out_ready <= (k % 4 == 3);
                    default: out_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Result checker and progress counter.
    always @(posedge i_clk) begin : sample_check
        t_out_beat want;
        if (rst_n) begin
            if (o_out_valid === 1'b1 && out_ready) begin
                results_seen <= results_seen + 1;
                if (expected_samples.size() == 0) begin
                    fail_count = fail_count + 1;
                    $display("%0t: unexpected beat, expected none, actual sample %0d cap %0b",
                             $time, o_out_beat.sample, o_out_beat.partial_cap_hit);
                end else begin
                    want = expected_samples.pop_front();
                    if (o_out_beat.sample !== want.sample) begin
                        fail_count = fail_count + 1;
                        $display("%0t: sample mismatch, expected %0d, actual %0d",
                                 $time, want.sample, o_out_beat.sample);
                    end
                    if (o_out_beat.partial_cap_hit !== want.partial_cap_hit) begin
                        fail_count = fail_count + 1;
                        $display("%0t: partial_cap_hit mismatch, expected %0b, actual %0b",
                                 $time, want.partial_cap_hit, o_out_beat.partial_cap_hit);
                    end
                end
            end
        end
        if ((in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Watchdog: ends the run when no beat moves on either side for too long.
    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("band_fill_wavetable_synth verification failed");
        $finish;
    end

endmodule
